/* rtl/mae_pkg.sv */
// Package for the mouse acceleration event filter.
// Holds event codes, register indexes and shared types; no dependencies.
package mae_pkg;

   localparam int TypeW = 5;
   localparam int CodeW = 10;
   localparam int ValW  = 32;

   localparam logic [TypeW-1:0] EV_SYN  = 5'd0;
   localparam logic [TypeW-1:0] EV_KEY  = 5'd1;
   localparam logic [TypeW-1:0] EV_REL  = 5'd2;
   localparam logic [TypeW-1:0] EV_MSC  = 5'd4;
   localparam logic [CodeW-1:0] CODE_X  = 10'd0;
   localparam logic [CodeW-1:0] CODE_Y  = 10'd1;
   localparam logic [CodeW-1:0] CODE_SCAN  = 10'd4;
   localparam logic [CodeW-1:0] CODE_SIDE  = 10'd275;
   localparam logic [CodeW-1:0] CODE_EXTRA = 10'd276;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_OFFSET = 3'd1;
   localparam logic [2:0] REG_GAIN   = 3'd2;
   localparam logic [2:0] REG_SENS   = 3'd3;
   localparam logic [2:0] REG_EXTRA  = 3'd4;
   localparam logic [2:0] REG_SIDE   = 3'd5;

   // Multiplier opcode handed to the serial unit.
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_CURVE_X, ST_FAC_X, ST_SENS_X,
      ST_MOVE_X, ST_CURVE_Y, ST_FAC_Y, ST_SENS_Y, ST_MOVE_Y, ST_EMIT
   } state_type;

endpackage

/* rtl/mae_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mae_pkg.
module mae_mul
   import mae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output logic        done,
   output logic [63:0] prod
);
   logic [63:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   logic        busy_ff, busy_in;

   // Add the shifted multiplicand when the low multiplier bit is set.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      if (req.start) begin
         acc_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         if (b_ff[63:1] == '0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = !busy_ff && !req.start;
   assign prod = acc_ff;
endmodule

/* rtl/mae_root.sv */
// Bit-serial integer square root, one result bit per cycle.
// Depends on mae_pkg.
module mae_root
   import mae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
   end

   assign done = !busy_ff && !start;
   assign root = root_ff[31:0];
endmodule

/* rtl/mouse_accel_event_filter.sv */
// Mouse acceleration event filter, top level.
// Timing: a pass-through or remapped event is registered and valid in the cycle after it is
// taken; a sync report gives its first result once the bit-serial multiplier steps and, in
// magnitude mode, the 32-step root have run.
// Flow: one item at a time; motion items back to back, others once all results are taken,
// and after a report only once its state machine is back in idle.
// Reset: synchronous active high; registers return to defaults, motion state clears.
// Depends on mae_pkg, mae_mul, mae_root.
module mouse_accel_event_filter
   import mae_pkg::*;
#(
   parameter int FRAC_BITS  = 16,
   parameter int DELTA_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // event_type[4:0], event_code[14:5], event_value[46:15]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_type[4:0], out_code[14:5], out_value[46:15]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int RW = FRAC_BITS + 2;
   localparam logic signed [DELTA_BITS-1:0] PLIM = {1'b0, {(DELTA_BITS-1){1'b1}}};
   localparam logic [63:0] FCAP = 64'd1 << 46;
   localparam logic [63:0] SCAP = (64'd1 << 38) - 64'd1;

   // Configuration registers.
   logic        mode_ff;
   logic [15:0] offset_ff, gain_ff, sens_ff;
   logic [9:0]  extra_ff, side_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1; offset_ff <= 16'd512; gain_ff <= 16'd3277;
         sens_ff <= 16'd4096; extra_ff <= 10'd29; side_ff <= 10'd192;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_data[0];
            REG_OFFSET: offset_ff <= csr_data;
            REG_GAIN:   gain_ff   <= csr_data;
            REG_SENS:   sens_ff   <= csr_data;
            REG_EXTRA:  extra_ff  <= csr_data[9:0];
            REG_SIDE:   side_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   logic [4:0]  ev_type;
   logic [9:0]  ev_code;
   logic signed [31:0] ev_val;
   assign ev_type = req_tdata[4:0];
   assign ev_code = req_tdata[14:5];
   assign ev_val  = req_tdata[46:15];

   state_type st_ff, st_in;
   logic signed [DELTA_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [RW-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [63:0] t_ff, t_in;   // scratch: square sum, then speed
   logic [63:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [31:0] mx_ff, mx_in, my_ff, my_in;
   logic [1:0]  eidx_ff, eidx_in;
   logic        ov_ff, ov_in, olast_ff, olast_in;
   logic [46:0] od_ff, od_in;
   mul_req_type mreq;
   logic        mdone, rstart, rdone;
   logic [63:0] mprod;
   logic [31:0] rroot;
   logic        mst_ff, mst_in;

   mae_mul u_mul (.clock, .reset, .req(mreq), .done(mdone), .prod(mprod));
   mae_root u_root (.clock, .reset, .start(rstart), .radicand(t_ff << 16),
                    .done(rdone), .root(rroot));

   function automatic logic [63:0] mag(input logic signed [63:0] v);
      mag = v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [DELTA_BITS-1:0] sat_add(
      input logic signed [DELTA_BITS-1:0] a, input logic signed [31:0] v);
      logic signed [33:0] s;
      s = 34'(signed'(a)) + 34'(v);
      if (s > 34'(PLIM)) sat_add = PLIM;
      else if (s < -34'(PLIM)) sat_add = -PLIM;
      else sat_add = s[DELTA_BITS-1:0];
   endfunction

   logic busy;
   assign busy = (st_ff != ST_IDLE) || ov_ff;
   assign req_tready = !busy;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // Per-step work values.
   logic [63:0] excess, factor, sens_cap;
   logic signed [63:0] dsel, tot;
   logic signed [RW-1:0] rsel;
   logic [63:0] tm, ip;
   always_comb begin
      excess = (t_ff > 64'(offset_ff)) ? t_ff - 64'(offset_ff) : 64'd0;
      factor = ((64'd1 << 24) + mprod) >> (24 - FRAC_BITS);
      if (factor > FCAP) factor = FCAP;
      sens_cap = (mprod >> 12) > SCAP ? SCAP : (mprod >> 12);
      dsel = (st_ff == ST_MOVE_X) ? 64'(px_ff) : 64'(py_ff);
      rsel = (st_ff == ST_MOVE_X) ? rx_ff : ry_ff;
      tot = (dsel < 0 ? -signed'(mprod) : signed'(mprod)) + 64'(rsel);
      tm  = mag(tot);
      ip  = tm >> FRAC_BITS;
   end

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:    if (acc && ev_type == EV_SYN && ev_code == CODE_X)
                        st_in = mode_ff ? ST_SQ_X : ST_CURVE_X;
         ST_SQ_X:    if (mst_ff && mdone) st_in = ST_SQ_Y;
         ST_SQ_Y:    if (mst_ff && mdone) st_in = ST_ROOT;
         ST_ROOT:    if (mst_ff && rdone) st_in = ST_CURVE_X;
         ST_CURVE_X: if (mst_ff && mdone) st_in = ST_FAC_X;
         ST_FAC_X:   if (mst_ff && mdone) st_in = ST_SENS_X;
         ST_SENS_X:  if (mst_ff && mdone) st_in = ST_MOVE_X;
         ST_MOVE_X:  if (mst_ff && mdone) st_in = ST_CURVE_Y;
         ST_CURVE_Y: if (mst_ff && mdone) st_in = ST_FAC_Y;
         ST_FAC_Y:   if (mst_ff && mdone) st_in = ST_SENS_Y;
         ST_SENS_Y:  if (mst_ff && mdone) st_in = ST_MOVE_Y;
         ST_MOVE_Y:  if (mst_ff && mdone) st_in = ST_EMIT;
         ST_EMIT:    if (!ov_ff && eidx_ff == 2'd3) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs; mst_ff marks that the unit has been started.
   always_comb begin
      px_in = px_ff; py_in = py_ff; rx_in = rx_ff; ry_in = ry_ff;
      t_in = t_ff; sx_in = sx_ff; sy_in = sy_ff; mx_in = mx_ff; my_in = my_ff;
      eidx_in = eidx_ff; ov_in = ov_ff; olast_in = olast_ff; od_in = od_ff;
      mreq = '{start: 1'b0, a: 64'd0, b: 64'd0};
      rstart = 1'b0;
      mst_in = mst_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            mst_in = 1'b0;
            if (acc) begin
               priority if (ev_type == EV_REL && ev_code == CODE_X)
                  px_in = sat_add(px_ff, ev_val);
               else if (ev_type == EV_REL && ev_code == CODE_Y)
                  py_in = sat_add(py_ff, ev_val);
               else if (ev_type == EV_SYN && ev_code == CODE_X) begin
                  t_in = mode_ff ? t_ff : (mag(64'(px_ff)) << 8);
                  eidx_in = 2'd0;
               end else if (ev_type == EV_KEY && ev_code == CODE_EXTRA) begin
                  od_in = {ev_val, extra_ff, EV_KEY}; ov_in = 1'b1; olast_in = 1'b1;
               end else if (ev_type == EV_KEY && ev_code == CODE_SIDE) begin
                  od_in = {ev_val, side_ff, EV_KEY}; ov_in = 1'b1; olast_in = 1'b1;
               end else if (ev_type == EV_MSC && ev_code == CODE_SCAN) begin
               end else begin
                  od_in = {ev_val, ev_code, ev_type}; ov_in = 1'b1; olast_in = 1'b1;
               end
            end
         end
         ST_SQ_X, ST_SQ_Y: begin
            if (!mst_ff) begin
               mreq = '{start: 1'b1,
                        a: mag(64'(st_ff == ST_SQ_X ? px_ff : py_ff)),
                        b: mag(64'(st_ff == ST_SQ_X ? px_ff : py_ff))};
               mst_in = 1'b1;
               if (st_ff == ST_SQ_X) t_in = '0;
            end else if (mdone) begin
               t_in = t_ff + mprod; mst_in = 1'b0;
            end
         end
         ST_ROOT: begin
            if (!mst_ff) begin rstart = 1'b1; mst_in = 1'b1; end
            else if (rdone) begin t_in = 64'(rroot); mst_in = 1'b0; end
         end
         ST_CURVE_X, ST_CURVE_Y: begin
            if (!mst_ff) begin
               mreq = '{start: 1'b1, a: excess, b: 64'(gain_ff)}; mst_in = 1'b1;
            end else if (mdone) mst_in = 1'b0;
         end
         ST_FAC_X, ST_FAC_Y: begin
            if (!mst_ff) begin
               mreq = '{start: 1'b1, a: factor, b: 64'(sens_ff)}; mst_in = 1'b1;
            end else if (mdone) mst_in = 1'b0;
         end
         ST_SENS_X, ST_SENS_Y: begin
            if (!mst_ff) begin
               if (st_ff == ST_SENS_X) sx_in = sens_cap; else sy_in = sens_cap;
               mreq = '{start: 1'b1,
                        a: mag(64'(st_ff == ST_SENS_X ? px_ff : py_ff)),
                        b: sens_cap};
               mst_in = 1'b1;
            end else if (mdone) mst_in = 1'b0;
         end
         ST_MOVE_X, ST_MOVE_Y: begin
            if (mst_ff && mdone) begin
               mst_in = 1'b0;
               if (st_ff == ST_MOVE_X) begin
                  rx_in = tot < 0 ? -RW'(tm[FRAC_BITS-1:0]) : RW'(tm[FRAC_BITS-1:0]);
                  mx_in = ip > 64'd2147483647 ? (tot < 0 ? -32'sd2147483647 : 32'sd2147483647)
                        : (tot < 0 ? -signed'(ip[31:0]) : signed'(ip[31:0]));
                  t_in  = mode_ff ? t_ff : (mag(64'(py_ff)) << 8);
               end else begin
                  ry_in = tot < 0 ? -RW'(tm[FRAC_BITS-1:0]) : RW'(tm[FRAC_BITS-1:0]);
                  my_in = ip > 64'd2147483647 ? (tot < 0 ? -32'sd2147483647 : 32'sd2147483647)
                        : (tot < 0 ? -signed'(ip[31:0]) : signed'(ip[31:0]));
                  px_in = '0; py_in = '0;
               end
            end else if (!mst_ff) begin
               mreq = '{start: 1'b1,
                        a: mag(64'(st_ff == ST_MOVE_X ? px_ff : py_ff)),
                        b: (st_ff == ST_MOVE_X) ? sx_ff : sy_ff};
               mst_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (!ov_ff || rsp_tready) begin
               unique case (eidx_ff)
                  2'd0: begin
                     eidx_in = 2'd1;
                     if (mx_ff != 0) begin
                        od_in = {mx_ff, CODE_X, EV_REL}; ov_in = 1'b1; olast_in = 1'b0;
                     end
                  end
                  2'd1: begin
                     eidx_in = 2'd2;
                     if (my_ff != 0) begin
                        od_in = {my_ff, CODE_Y, EV_REL}; ov_in = 1'b1; olast_in = 1'b0;
                     end
                  end
                  2'd2: begin
                     eidx_in = 2'd3;
                     od_in = {32'd0, CODE_X, EV_SYN}; ov_in = 1'b1; olast_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      // magnitude mode shares one speed for both axes
      if (st_ff == ST_MOVE_X && mode_ff && mst_ff && mdone) t_in = t_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0; mst_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; rx_ff <= '0; ry_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; mst_ff <= mst_in;
         px_ff <= px_in; py_ff <= py_in; rx_ff <= rx_in; ry_ff <= ry_in;
      end
      t_ff <= t_in; sx_ff <= sx_in; sy_ff <= sy_in; mx_ff <= mx_in; my_ff <= my_in;
      eidx_ff <= eidx_in; olast_ff <= olast_in; od_ff <= od_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {1'b0, od_ff};
   assign rsp_tlast  = olast_ff;

   // No new item while a result is waiting.
   a_noacc: assert property (@(posedge clock) disable iff (reset) ov_ff |-> !req_tready)
      else $error("item accepted while result pending");
   // The unit is never started twice back to back.
   a_mstart: assert property (@(posedge clock) disable iff (reset)
      mreq.start |=> !mreq.start)
      else $error("multiplier restarted");
   // Motion sums are cleared when the sync report leaves the last move step.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_MOVE_Y && st_in == ST_EMIT) |=> (px_ff == '0 && py_ff == '0))
      else $error("pending motion not cleared");
endmodule
